FILE: hdl/aos_pkg.sv
// Shared types and constants for the oversampling offset/scale block.
// No dependencies; aos_front, aos_back and the top level refer to this package by scoped name.

package aos_pkg;

  // Register map, index = paddr[3:2]
  localparam logic [1:0] REG_OS_BITS = 2'd0;
  localparam logic [1:0] REG_OFFSET  = 2'd1;
  localparam logic [1:0] REG_NUM     = 2'd2;
  localparam logic [1:0] REG_DEN     = 2'd3;

  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OS_W     = 2;
  localparam int unsigned OFFSET_W = 14;
  localparam int unsigned SCALE_W  = 32;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned GRP_W    = 5;

  localparam logic [OS_W-1:0]    OS_BITS_RST = '0;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = '0;
  localparam logic [SCALE_W-1:0] NUM_RST     = SCALE_W'(1);
  localparam logic [SCALE_W-1:0] DEN_RST     = SCALE_W'(1);

  localparam int unsigned DIV_STEPS = OUT_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [OS_W-1:0]     os_bits;
    logic [OFFSET_W-1:0] offset;
  } front_cfg_t;

  typedef struct packed {
    logic [SCALE_W-1:0] num;
    logic [SCALE_W-1:0] den;
  } scale_cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_CMP  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_HOLD = 5'b10000
  } back_state_e;

  // Samples per group for an oversample setting; setting three means one sample.
  function automatic logic [GRP_W-1:0] group_size(input logic [OS_W-1:0] bits);
    logic [GRP_W-1:0] size;
    unique case (bits)
      2'd1:    size = GRP_W'(4);
      2'd2:    size = GRP_W'(16);
      default: size = GRP_W'(1);
    endcase
    return size;
  endfunction

endpackage

FILE: hdl/aos_front.sv
// Front end: accumulates samples into groups, decimates and removes the idle offset.
// Depends on aos_pkg; feeds aos_queue.

module aos_front #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned DEC_W       = SAMPLE_BITS + 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  aos_pkg::front_cfg_t    cfg_i,
  input  logic                   push_i,
  input  logic [SAMPLE_BITS-1:0] raw_sample_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output logic [DEC_W-1:0]       q_data_o
);

  localparam int unsigned DIFF_W =
    (DEC_W > aos_pkg::OFFSET_W) ? DEC_W : aos_pkg::OFFSET_W;

  logic [DEC_W-1:0]          sum_q, sum_d, sum_n;
  logic [aos_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_n;
  logic                      accept, done;
  logic [DEC_W-1:0]          dec;
  logic [DIFF_W-1:0]         dec_x, off_x;

  assign accept = push_i && !q_full_i;
  assign sum_n  = sum_q + DEC_W'(raw_sample_i);
  assign cnt_n  = cnt_q + aos_pkg::CNT_W'(1);
  // count wraps at sixteen, which closes the largest group
  assign done   = (cnt_n == '0) ||
                  ({1'b0, cnt_n} >= aos_pkg::group_size(cfg_i.os_bits));

  assign dec   = sum_n >> cfg_i.os_bits;
  assign dec_x = DIFF_W'(dec);
  assign off_x = DIFF_W'(cfg_i.offset);

  // floor at zero when the offset reaches the value
  assign q_data_o = (dec_x > off_x) ? DEC_W'(dec_x - off_x) : '0;
  assign q_push_o = accept && done;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (accept) begin
      sum_d = done ? '0 : sum_n;
      cnt_d = done ? '0 : cnt_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hdl/aos_queue.sv
// Two-entry queue of decimated words between the front end and the scaler.
// Depends on aos_pkg only through the modules around it.

module aos_queue #(
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, wr_d, rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/aos_back.sv
// Back end: multiplies by the numerator, divides by the denominator one bit a cycle,
// clamps to 16 bits and holds the result word. Depends on aos_pkg.

module aos_back #(
  parameter int unsigned DEC_W = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  aos_pkg::scale_cfg_t         cfg_i,
  input  logic                        q_valid_i,
  input  logic [DEC_W-1:0]            q_data_i,
  output logic                        q_pop_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [aos_pkg::OUT_W-1:0]   scaled_value_o,
  output logic                        saturated_o
);

  localparam int unsigned PROD_W = DEC_W + aos_pkg::SCALE_W;
  localparam int unsigned HI_W   = PROD_W - aos_pkg::OUT_W;
  localparam int unsigned CMP_W  = (HI_W > aos_pkg::SCALE_W) ? HI_W : aos_pkg::SCALE_W;
  localparam int unsigned REM_W  = aos_pkg::SCALE_W;

  aos_pkg::back_state_e state_q, state_d;

  logic [DEC_W-1:0]           dec_q, dec_d;
  logic [PROD_W-1:0]          prod_q, prod_d;
  logic [REM_W-1:0]           rem_q, rem_d;
  logic [aos_pkg::OUT_W-1:0]  quo_q, quo_d;
  logic                       sat_q, sat_d;
  logic [aos_pkg::STEP_W-1:0] step_q, step_d;
  logic                       out_valid_q, out_valid_d;
  logic [aos_pkg::OUT_W-1:0]  out_val_q, out_val_d;
  logic                       out_sat_q, out_sat_d;

  logic             out_free;
  logic             too_big;
  logic [REM_W:0]   trial;
  logic             fits;

  assign out_free = !out_valid_q || pop_i;
  // quotient exceeds 16 bits exactly when the product's upper part reaches the divisor;
  // a zero divisor always lands here
  assign too_big  = CMP_W'(prod_q >> aos_pkg::OUT_W) >= CMP_W'(cfg_i.den);
  assign trial    = {rem_q, quo_q[aos_pkg::OUT_W-1]};
  assign fits     = trial >= {1'b0, cfg_i.den};

  always_comb begin
    state_d     = state_q;
    dec_d       = dec_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    sat_d       = sat_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !pop_i;
    out_val_d   = out_val_q;
    out_sat_d   = out_sat_q;
    q_pop_o     = 1'b0;
    unique case (state_q)
      aos_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          dec_d   = q_data_i;
          q_pop_o = 1'b1;
          state_d = aos_pkg::ST_MUL;
        end
      end
      aos_pkg::ST_MUL: begin
        prod_d  = PROD_W'(dec_q) * PROD_W'(cfg_i.num);
        state_d = aos_pkg::ST_CMP;
      end
      aos_pkg::ST_CMP: begin
        if (too_big) begin
          quo_d   = '1;
          sat_d   = 1'b1;
          state_d = aos_pkg::ST_HOLD;
        end else begin
          // remainder starts below the divisor; low product bits shift in one a step
          rem_d   = REM_W'(prod_q >> aos_pkg::OUT_W);
          quo_d   = prod_q[aos_pkg::OUT_W-1:0];
          sat_d   = 1'b0;
          step_d  = '0;
          state_d = aos_pkg::ST_DIV;
        end
      end
      aos_pkg::ST_DIV: begin
        rem_d  = fits ? REM_W'(trial - {1'b0, cfg_i.den}) : REM_W'(trial);
        quo_d  = {quo_q[aos_pkg::OUT_W-2:0], fits};
        step_d = step_q + aos_pkg::STEP_W'(1);
        if (step_q == aos_pkg::STEP_W'(aos_pkg::DIV_STEPS - 1)) begin
          state_d = aos_pkg::ST_HOLD;
        end
      end
      aos_pkg::ST_HOLD: begin
        // wait here while the previous word is still unread
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = quo_q;
          out_sat_d   = sat_q;
          state_d     = aos_pkg::ST_IDLE;
        end
      end
      default: state_d = aos_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aos_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dec_q     <= dec_d;
    prod_q    <= prod_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    sat_q     <= sat_d;
    out_val_q <= out_val_d;
    out_sat_q <= out_sat_d;
  end

  assign empty_o        = !out_valid_q;
  assign scaled_value_o = out_val_q;
  assign saturated_o    = out_sat_q;

endmodule

FILE: hdl/adc_oversample_offset_scale.sv
// Converter oversampling front end: group sum, decimation, offset removal and ratio scaling.
// Top level; depends on aos_pkg, aos_front, aos_queue and aos_back.
//
// Samples enter through push/full, one per cycle while full is low. Every 1, 4 or 16
// samples (oversample_bits) close a group; the decimated, offset-corrected word moves
// through a two-entry queue to the scaler. The scaler multiplies by scale_numerator,
// checks for overflow, then runs a 16-step shift-subtract divide by scale_denominator,
// one quotient bit per cycle. A result word passes the queue, then the scaler states idle,
// multiply, compare, divide (skipped when it saturates) and hold, into the output register
// (empty low); the scaler takes a new word only when done with the last, while samples
// that do not close a group are taken every cycle as long as the queue has room.
// Results wait in an output register read through empty/pop. While the receiver does
// not pop, the scaler holds its finished word, the queue fills and full rises.
// Reset clears the group sum and count, the queue and the output register, and loads
// oversample_bits 0, idle_offset 0, scale_numerator 1 and scale_denominator 1.
// Registers sit on an APB port at byte addresses 0, 4, 8 and 12; write them only while
// no group result is pending.

module adc_oversample_offset_scale #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [aos_pkg::ADDR_W-1:0]   paddr,
  input  logic [aos_pkg::DATA_W-1:0]   pwdata,
  output logic [aos_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         push,
  output logic                         full,
  input  logic [SAMPLE_BITS-1:0]       raw_sample_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [aos_pkg::OUT_W-1:0]    scaled_value_o,
  output logic                         saturated_o
);

  localparam int unsigned DEC_W = SAMPLE_BITS + 4;

  logic [aos_pkg::OS_W-1:0]     os_bits_q, os_bits_d;
  logic [aos_pkg::OFFSET_W-1:0] offset_q, offset_d;
  logic [aos_pkg::SCALE_W-1:0]  num_q, num_d, den_q, den_d;
  logic                         wr_en;
  logic [1:0]                   reg_idx;

  aos_pkg::front_cfg_t front_cfg;
  aos_pkg::scale_cfg_t scale_cfg;

  logic             fq_push, q_full, q_valid, q_pop;
  logic [DEC_W-1:0] fq_data, q_data;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    os_bits_d = os_bits_q;
    offset_d  = offset_q;
    num_d     = num_q;
    den_d     = den_q;
    if (wr_en) begin
      unique case (reg_idx)
        aos_pkg::REG_OS_BITS: os_bits_d = pwdata[aos_pkg::OS_W-1:0];
        aos_pkg::REG_OFFSET:  offset_d  = pwdata[aos_pkg::OFFSET_W-1:0];
        aos_pkg::REG_NUM:     num_d     = pwdata[aos_pkg::SCALE_W-1:0];
        aos_pkg::REG_DEN:     den_d     = pwdata[aos_pkg::SCALE_W-1:0];
        default:              ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      aos_pkg::REG_OS_BITS: prdata = aos_pkg::DATA_W'(os_bits_q);
      aos_pkg::REG_OFFSET:  prdata = aos_pkg::DATA_W'(offset_q);
      aos_pkg::REG_NUM:     prdata = aos_pkg::DATA_W'(num_q);
      aos_pkg::REG_DEN:     prdata = aos_pkg::DATA_W'(den_q);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      os_bits_q <= aos_pkg::OS_BITS_RST;
      offset_q  <= aos_pkg::OFFSET_RST;
      num_q     <= aos_pkg::NUM_RST;
      den_q     <= aos_pkg::DEN_RST;
    end else begin
      os_bits_q <= os_bits_d;
      offset_q  <= offset_d;
      num_q     <= num_d;
      den_q     <= den_d;
    end
  end

  assign front_cfg.os_bits = os_bits_q;
  assign front_cfg.offset  = offset_q;
  assign scale_cfg.num     = num_q;
  assign scale_cfg.den     = den_q;
  assign full              = q_full;

  aos_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .DEC_W      (DEC_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (front_cfg),
    .push_i      (push),
    .raw_sample_i(raw_sample_i),
    .q_full_i    (q_full),
    .q_push_o    (fq_push),
    .q_data_o    (fq_data)
  );

  aos_queue #(
    .WIDTH(DEC_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fq_push),
    .data_i (fq_data),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .data_o (q_data)
  );

  aos_back #(
    .DEC_W(DEC_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (scale_cfg),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .scaled_value_o(scaled_value_o),
    .saturated_o   (saturated_o)
  );

  // a saturated word always carries the clamp value
  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && saturated_o) |-> (scaled_value_o == '1))
    else $error("saturated result without clamp value");

  // a full queue always offers a word to the scaler
  a_full_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> q_valid)
    else $error("queue full but no word visible");

  // the scaler only takes a word that the queue offers
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("scaler popped an empty queue");

  // a denominator write lands in the register
  a_den_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && reg_idx == aos_pkg::REG_DEN) |=> (den_q == $past(pwdata)))
    else $error("denominator write lost");

endmodule
